### design/ots_pkg.sv
// Shared constants, types and helper functions of the overlap-add time stretch block.
package ots_pkg;

  localparam int unsigned WINDOW_FRAMES  = 64;
  localparam int unsigned OVERLAP_FRAMES = 16;
  localparam int unsigned OUT_HOP_FRAMES = 16;
  localparam int unsigned MAX_CHANNELS   = 2;

  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned FRAME_W  = $clog2(WINDOW_FRAMES);
  localparam int unsigned CH_W     = $clog2(MAX_CHANNELS);
  localparam int unsigned OVL_W    = $clog2(OVERLAP_FRAMES);
  localparam int unsigned CHCNT_W  = $clog2(MAX_CHANNELS + 1);
  localparam int unsigned FSS_W    = FRAME_W + 2;
  localparam int unsigned FRAME_AW = FRAME_W + CH_W;
  localparam int unsigned TAIL_AW  = OVL_W + CH_W;
  localparam int unsigned ACC_W    = SAMPLE_W + OVL_W + 2;

  localparam int unsigned USER_W      = 11;
  localparam int unsigned CHASE_W     = 10;
  localparam int unsigned CFG_W       = 11;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned SPEED_W     = 11;
  localparam int unsigned SPEED_PROD_W = USER_W + CHASE_W;
  localparam int unsigned HOP_PROD_W  = SPEED_W + OVL_W + 1;

  localparam int unsigned SPEED_MIN = 64;
  localparam int unsigned SPEED_MAX = 1024;
  localparam int unsigned UNITY_Q8  = 256;
  localparam int unsigned CHASE_MIN = 256;
  localparam int unsigned CHASE_MAX = 512;
  localparam int unsigned Q8_SHIFT  = 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_USER_SPEED    = 2'd0,
    REG_CHASE_SPEED   = 2'd1,
    REG_CHANNEL_COUNT = 2'd2
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD_CUR,
    ST_RD_NXT,
    ST_BLEND,
    ST_PUT
  } state_e;

  function automatic logic [USER_W-1:0] clamp_user(input logic [USER_W-1:0] v);
    if (v < USER_W'(SPEED_MIN)) return USER_W'(SPEED_MIN);
    if (v > USER_W'(SPEED_MAX)) return USER_W'(SPEED_MAX);
    return v;
  endfunction

  function automatic logic [CHASE_W-1:0] clamp_chase(input logic [CHASE_W-1:0] v);
    if (v < CHASE_W'(CHASE_MIN)) return CHASE_W'(CHASE_MIN);
    if (v > CHASE_W'(CHASE_MAX)) return CHASE_W'(CHASE_MAX);
    return v;
  endfunction

  function automatic logic [CHCNT_W-1:0] clamp_channels(input logic [1:0] v);
    if (v == 2'd0) return CHCNT_W'(1);
    if (CHCNT_W'(v) > CHCNT_W'(MAX_CHANNELS)) return CHCNT_W'(MAX_CHANNELS);
    return CHCNT_W'(v);
  endfunction

endpackage

### design/ots_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module ots_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### design/ots_blend.sv
// Linear crossfade of one tail sample into one window sample, truncated and saturated.
module ots_blend import ots_pkg::*; (
  input  logic signed [SAMPLE_W-1:0] tail_i,
  input  logic signed [SAMPLE_W-1:0] cur_i,
  input  logic [OVL_W-1:0]           pos_i,
  input  logic                       have_prev_i,
  output logic signed [SAMPLE_W-1:0] sample_o
);

  logic [OVL_W:0]           w_tail;
  logic signed [ACC_W-1:0]  tail_x;
  logic signed [ACC_W-1:0]  cur_x;
  logic signed [ACC_W-1:0]  acc;
  logic signed [ACC_W-1:0]  biased;
  logic signed [ACC_W-1:0]  quot;
  logic signed [SAMPLE_W-1:0] sat;

  always_comb begin
    w_tail = (OVL_W + 1)'(OVERLAP_FRAMES) - {1'b0, pos_i};
    tail_x = ACC_W'(tail_i);
    cur_x  = ACC_W'(cur_i);
    acc    = tail_x * $signed(ACC_W'(w_tail)) + cur_x * $signed(ACC_W'(pos_i));
    // round toward zero: bias negative sums before the arithmetic shift
    biased = acc[ACC_W-1] ? acc + $signed(ACC_W'(OVERLAP_FRAMES - 1)) : acc;
    quot   = biased >>> OVL_W;
    if (quot > $signed(ACC_W'(32767))) begin
      sat = 16'sh7fff;
    end else if (quot < -$signed(ACC_W'(32768))) begin
      sat = 16'sh8000;
    end else begin
      sat = quot[SAMPLE_W-1:0];
    end
    sample_o = have_prev_i ? sat : cur_i;
  end

endmodule

### design/ola_time_stretch.sv
// Top level of the overlap-add time stretch block with linear crossfade.
//
//  channel  | direction | handshake                | payload
//  ---------+-----------+--------------------------+-----------------------------
//  in       | request   | in_valid_i / in_ready_o  | sample_in_i (s16)
//  out      | response  | out_valid_o / out_ready_i| sample_out_o (s16), last_o
//  cfg      | write     | cfg_we_i                 | cfg_index_i, cfg_data_i
//
// Timing: at unity speed an accepted sample is registered straight into the output. Otherwise
// a sample is stored, and a sample that completes a window starts a burst of
// OVERLAP_FRAMES x MAX_CHANNELS entries (32), each passing ST_RD_CUR, ST_RD_NXT,
// ST_BLEND and ST_PUT in turn, with ST_PUT held by output stalls; the single read
// port of the frame RAM, read twice per entry, sets that sequence.
// Reset clears all control state; the frame and tail RAMs are not cleared.
// A stalled output holds the sequencer in its output state and blocks new requests.
module ola_time_stretch import ots_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic signed [SAMPLE_W-1:0] sample_in_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic signed [SAMPLE_W-1:0] sample_out_o,
  output logic                       last_o,
  input  logic                       cfg_we_i,
  input  logic [CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [CFG_W-1:0]           cfg_data_i
);

  // configuration, held clamped to the legal range
  logic [USER_W-1:0]  user_q;
  logic [CHASE_W-1:0] chase_q;
  logic [CHCNT_W-1:0] chcnt_q;

  // stream state
  state_e               state_q, state_d;
  logic                 have_prev_q;
  logic [CH_W-1:0]      ci_q;
  logic signed [FSS_W-1:0] fss_q;
  logic [FRAME_W-1:0]   wp_q;
  logic [FRAME_W-1:0]   start_q;
  logic [OVL_W-1:0]     pos_q;
  logic [CH_W-1:0]      ch_q;
  logic signed [SAMPLE_W-1:0] cur_q;
  logic signed [SAMPLE_W-1:0] blend_q;

  // output register
  logic                       out_valid_q;
  logic signed [SAMPLE_W-1:0] out_sample_q;
  logic                       out_last_q;

  // speed path
  logic [SPEED_PROD_W-1:0] speed_prod;
  logic [SPEED_PROD_W-1:0] speed_scaled;
  logic [SPEED_W-1:0]      eff;
  logic                    passthru;
  logic [HOP_PROD_W-1:0]   hop_prod;
  logic [HOP_PROD_W-1:0]   hop_raw;
  logic [FSS_W-1:0]        hop;

  // RAM ports
  logic                 frame_we, frame_re;
  logic [FRAME_AW-1:0]  frame_waddr, frame_raddr;
  logic [SAMPLE_W-1:0]  frame_rdata;
  logic                 tail_we, tail_re;
  logic [TAIL_AW-1:0]   tail_addr;
  logic [SAMPLE_W-1:0]  tail_rdata;

  // control
  logic                    out_free;
  logic                    in_fire;
  logic                    frame_done;
  logic signed [FSS_W-1:0] fss_inc;
  logic                    window_done;
  logic                    emit_en;
  logic                    emit_fire;
  logic                    advance;
  logic                    burst_end;
  logic                    emit_last;
  logic signed [SAMPLE_W-1:0] blend_val;

  // Effective speed: product of clamped registers, back to Q8, clamped again.
  always_comb begin
    speed_prod   = SPEED_PROD_W'(user_q) * SPEED_PROD_W'(chase_q);
    speed_scaled = speed_prod >> Q8_SHIFT;
    if (speed_scaled < SPEED_PROD_W'(SPEED_MIN)) begin
      eff = SPEED_W'(SPEED_MIN);
    end else if (speed_scaled > SPEED_PROD_W'(SPEED_MAX)) begin
      eff = SPEED_W'(SPEED_MAX);
    end else begin
      eff = speed_scaled[SPEED_W-1:0];
    end
    passthru = (eff == SPEED_W'(UNITY_Q8));
    hop_prod = HOP_PROD_W'(OUT_HOP_FRAMES) * HOP_PROD_W'(eff);
    hop_raw  = hop_prod >> Q8_SHIFT;
    hop      = (hop_raw == '0) ? FSS_W'(1) : hop_raw[FSS_W-1:0];
  end

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == ST_IDLE) && out_free;
  assign in_fire    = in_valid_i && in_ready_o;

  // Frame closes when the channel just stored is the last of the frame.
  assign frame_done  = (CHCNT_W'(ci_q) + CHCNT_W'(1)) >= chcnt_q;
  assign fss_inc     = fss_q + FSS_W'(1);
  assign window_done = frame_done && (fss_inc >= $signed(FSS_W'(WINDOW_FRAMES)));

  // Burst walks every (frame, channel) pair of the overlap; only live channels emit.
  assign emit_en   = CHCNT_W'(ch_q) < chcnt_q;
  assign emit_last = (pos_q == OVL_W'(OVERLAP_FRAMES - 1)) &&
                     (CHCNT_W'(ch_q) + CHCNT_W'(1) == chcnt_q);
  assign burst_end = (pos_q == OVL_W'(OVERLAP_FRAMES - 1)) &&
                     (ch_q == CH_W'(MAX_CHANNELS - 1));
  assign emit_fire = (state_q == ST_PUT) && emit_en && out_free;
  assign advance   = (state_q == ST_PUT) && (!emit_en || out_free);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire && !passthru && window_done) begin
          state_d = ST_RD_CUR;
        end
      end
      ST_RD_CUR: state_d = ST_RD_NXT;
      ST_RD_NXT: state_d = ST_BLEND;
      ST_BLEND:  state_d = ST_PUT;
      ST_PUT: begin
        if (advance) begin
          state_d = burst_end ? ST_IDLE : ST_RD_CUR;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // RAM controls per state
  always_comb begin
    frame_we    = 1'b0;
    frame_waddr = {wp_q, ci_q};
    frame_re    = 1'b0;
    frame_raddr = {start_q + FRAME_W'(pos_q), ch_q};
    tail_we     = 1'b0;
    tail_re     = 1'b0;
    tail_addr   = {pos_q, ch_q};
    case (state_q)
      ST_IDLE: begin
        frame_we = in_fire && !passthru;
      end
      ST_RD_CUR: begin
        frame_re = 1'b1;
        tail_re  = 1'b1;
      end
      ST_RD_NXT: begin
        // fetch the frame that becomes the next tail at this position
        frame_re    = 1'b1;
        frame_raddr = {start_q + FRAME_W'(OVERLAP_FRAMES) + FRAME_W'(pos_q), ch_q};
      end
      ST_BLEND: begin
        tail_we = 1'b1;
      end
      ST_PUT: begin
        frame_re = 1'b0;
      end
      default: begin
        frame_we = 1'b0;
      end
    endcase
  end

  ots_ram #(
    .WIDTH(SAMPLE_W),
    .DEPTH(WINDOW_FRAMES * MAX_CHANNELS)
  ) u_frame_ram (
    .clk_i  (clk_i),
    .we_i   (frame_we),
    .waddr_i(frame_waddr),
    .wdata_i(sample_in_i),
    .re_i   (frame_re),
    .raddr_i(frame_raddr),
    .rdata_o(frame_rdata)
  );

  ots_ram #(
    .WIDTH(SAMPLE_W),
    .DEPTH(OVERLAP_FRAMES * MAX_CHANNELS)
  ) u_tail_ram (
    .clk_i  (clk_i),
    .we_i   (tail_we),
    .waddr_i(tail_addr),
    .wdata_i(frame_rdata),
    .re_i   (tail_re),
    .raddr_i(tail_addr),
    .rdata_o(tail_rdata)
  );

  ots_blend u_blend (
    .tail_i     ($signed(tail_rdata)),
    .cur_i      (cur_q),
    .pos_i      (pos_q),
    .have_prev_i(have_prev_q),
    .sample_o   (blend_val)
  );

  // Control and stream state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      user_q      <= USER_W'(UNITY_Q8);
      chase_q     <= CHASE_W'(UNITY_Q8);
      chcnt_q     <= CHCNT_W'(MAX_CHANNELS);
      have_prev_q <= 1'b0;
      ci_q        <= '0;
      fss_q       <= '0;
      wp_q        <= '0;
      start_q     <= '0;
      pos_q       <= '0;
      ch_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;

      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_USER_SPEED:    user_q  <= clamp_user(cfg_data_i[USER_W-1:0]);
          REG_CHASE_SPEED:   chase_q <= clamp_chase(cfg_data_i[CHASE_W-1:0]);
          REG_CHANNEL_COUNT: chcnt_q <= clamp_channels(cfg_data_i[1:0]);
          default: begin
            chcnt_q <= chcnt_q;
          end
        endcase
      end

      if (in_fire && !passthru) begin
        if (!frame_done) begin
          ci_q <= ci_q + CH_W'(1);
        end else begin
          ci_q <= '0;
          wp_q <= wp_q + FRAME_W'(1);
          if (window_done) begin
            // oldest frame of the complete window sits at the advanced pointer
            start_q <= wp_q + FRAME_W'(1);
            pos_q   <= '0;
            ch_q    <= '0;
            fss_q   <= fss_inc - $signed(hop);
          end else begin
            fss_q <= fss_inc;
          end
        end
      end

      if (advance) begin
        if (ch_q == CH_W'(MAX_CHANNELS - 1)) begin
          ch_q  <= '0;
          pos_q <= pos_q + OVL_W'(1);
        end else begin
          ch_q <= ch_q + CH_W'(1);
        end
        if (burst_end) begin
          have_prev_q <= 1'b1;
        end
      end

      if ((in_fire && passthru) || emit_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (state_q == ST_RD_NXT) begin
      cur_q <= $signed(frame_rdata);
    end
    if (state_q == ST_BLEND) begin
      blend_q <= blend_val;
    end
    if (in_fire && passthru) begin
      out_sample_q <= sample_in_i;
      out_last_q   <= 1'b1;
    end else if (emit_fire) begin
      out_sample_q <= blend_q;
      out_last_q   <= emit_last;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign sample_out_o = out_sample_q;
  assign last_o       = out_last_q;

endmodule
